/* hdl/qem_pkg.sv */
// ----------------------------------------------------------------------------
// qem_pkg
// Shared types and constants for the quantization error metrics unit.
// ----------------------------------------------------------------------------
package qem_pkg;

  typedef struct packed {
    logic signed [31:0] original_value;
    logic signed [31:0] quantized_value;
    logic               set_end;
  } qem_in_t;

  typedef struct packed {
    logic [4:0]  metric_index;
    logic [63:0] metric_value;
    logic        last_metric;
  } qem_out_t;

  localparam logic [1:0] CFG_BIN_COUNT = 2'd0;
  localparam logic [1:0] CFG_ABS_LIMIT = 2'd1;
  localparam logic [1:0] CFG_REL_LIMIT = 2'd2;

  localparam logic [4:0] MET_MAX_ABS  = 5'd0;
  localparam logic [4:0] MET_MEAN_ABS = 5'd1;
  localparam logic [4:0] MET_MSE      = 5'd2;
  localparam logic [4:0] MET_RMSE     = 5'd3;
  localparam logic [4:0] MET_MAX_REL  = 5'd4;
  localparam logic [4:0] MET_MEAN_REL = 5'd5;
  localparam logic [4:0] MET_COUNT    = 5'd6;
  localparam logic [4:0] MET_P10      = 5'd7;
  localparam logic [4:0] MET_PASS     = 5'd16;

  localparam int unsigned PctCount = 9;

  // Divider opcode (start request to the shared divider)
  typedef struct packed {
    logic        start;
    logic [79:0] dividend;
    logic [63:0] divisor;
  } qem_div_req_t;

endpackage

/* hdl/qem_ram.sv */
// ----------------------------------------------------------------------------
// qem_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qem_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hdl/qem_divider.sv */
// ----------------------------------------------------------------------------
// qem_divider
// Restoring divider, one quotient bit per cycle: 80-bit dividend / 64-bit divisor.
// ----------------------------------------------------------------------------
module qem_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qem_pkg::qem_div_req_t req_i,
  output logic                  busy_o,
  output logic [79:0]           quot_o
);
  import qem_pkg::*;

  logic [79:0] quot_q, quot_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[63:0], quot_q[79]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd79;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[78:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[78:0], 1'b0};
      end
      if (cnt_q == 7'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

/* hdl/quant_error_metrics_unit.sv */
// ----------------------------------------------------------------------------
// quant_error_metrics_unit
// Error statistics over sets of Q16.16 original/quantized value pairs.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transaction per pair; set_end marks the last pair of a set.
//   out channel : after a set_end pair, 17 metric transactions, index 0..16,
//                 last_metric high on the pass flag.
//   cfg channel : index 0 bin count, 1 abs error limit, 2 rel error limit.
// Sequence: a pair is processed to the end before the next is accepted: the
//   relative error in the shared serial divider, then accumulate and a histogram
//   read-modify-write (no write when its error falls outside the histogram). A
//   report adds three divides, a square root, a total sweep over the bins in
//   use, nine percentile scans over the bins each followed by a divide, an emit
//   per result, and a clearing sweep of the histogram RAM.
// Reset: control, config and accumulator registers return to defaults, then the
//   block runs a clearing pass over the histogram before taking the first pair.
// Stalls: a result is held in the output register until taken; the sequencer
//   prepares the next metric and then waits for the register to free. The input
//   stays not ready until the report and the clearing sweep are done.
// ----------------------------------------------------------------------------
module quant_error_metrics_unit #(
  parameter int MaxBins = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qem_pkg::qem_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qem_pkg::qem_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import qem_pkg::*;

  localparam int AW = $clog2(MaxBins);
  localparam int CW = $clog2(MaxBins + 1);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RDIV  = 5'd2;
  localparam logic [4:0] S_ACC   = 5'd3;
  localparam logic [4:0] S_HRD   = 5'd4;
  localparam logic [4:0] S_HWR   = 5'd5;
  localparam logic [4:0] S_MDIV  = 5'd6;
  localparam logic [4:0] S_MWAIT = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_TOT   = 5'd9;
  localparam logic [4:0] S_TOTW  = 5'd10;
  localparam logic [4:0] S_PSCAN = 5'd11;
  localparam logic [4:0] S_PCHK  = 5'd12;
  localparam logic [4:0] S_PDIV  = 5'd13;
  localparam logic [4:0] S_EMIT  = 5'd14;
  localparam logic [4:0] S_WOUT  = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_PMUL  = 5'd17;

  logic [4:0]  state_q, state_d;
  logic [7:0]  bin_count_q;
  logic [31:0] abs_lim_q, rel_lim_q;

  logic [31:0] max_abs_q, max_abs_d, max_rel_q, max_rel_d, cnt_q, cnt_d;
  logic [63:0] sum_abs_q, sum_abs_d, sum_sq_q, sum_sq_d, sum_rel_q, sum_rel_d;
  logic        set_end_q, set_end_d;
  logic [32:0] diff_q, diff_d;
  logic        mag_zero_q, mag_zero_d;
  logic [31:0] ae_q, ae_d;
  logic [AW-1:0] bin_q, bin_d;
  logic        bin_ok_q, bin_ok_d;

  logic [CW-1:0] idx_q, idx_d;
  logic [4:0]  met_q, met_d;
  logic [63:0] val_q, val_d;
  logic [63:0] tot_q, tot_d;
  logic [63:0] cum_q, cum_d;
  logic [67:0] need_q, need_d;
  logic [3:0]  k_q, k_d;

  logic [79:0] sq_rad_q, sq_rad_d;
  logic [41:0] sq_rem_q, sq_rem_d;
  logic [39:0] sq_root_q, sq_root_d;
  logic [5:0]  sq_cnt_q, sq_cnt_d;

  logic        out_valid_q, out_valid_d;
  qem_out_t    out_q, out_d;

  qem_div_req_t div_req;
  logic        div_busy;
  logic [79:0] div_quot;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [CW-1:0] n_bins;
  logic [32:0]   mag;
  logic [63:0]   ae_sq;
  logic [40:0]   ae_bin;
  logic [41:0]   sq_trial, sq_rem_sh;
  logic [67:0]   cum10;
  logic [63:0]   cum_next;

  qem_divider u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(div_req),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  qem_ram #(.Width(32), .Depth(MaxBins)) u_bins (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  assign n_bins = ({24'd0, bin_count_q} > MaxBins) ? CW'(MaxBins) : CW'(bin_count_q);

  assign mag = in_data_i.original_value[31] ?
               33'(-{in_data_i.original_value[31], in_data_i.original_value}) :
               {1'b0, in_data_i.original_value};
  assign ae_sq     = ae_q * ae_q;
  assign ae_bin    = 41'(ae_q) * 41'(n_bins);
  assign sq_rem_sh = {sq_rem_q[39:0], sq_rad_q[79:78]};
  assign sq_trial  = {sq_root_q, 2'b01};
  assign cum_next  = sat_add(cum_q, {32'd0, ram_rdata});
  assign cum10     = {4'd0, cum_q} * 68'd10;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_CLR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= 8'd100;
      abs_lim_q   <= 32'd65536;
      rel_lim_q   <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BIN_COUNT: bin_count_q <= cfg_data_i[7:0];
        CFG_ABS_LIMIT: abs_lim_q   <= cfg_data_i;
        CFG_REL_LIMIT: rel_lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    max_abs_d = max_abs_q; max_rel_d = max_rel_q; cnt_d = cnt_q;
    sum_abs_d = sum_abs_q; sum_sq_d = sum_sq_q; sum_rel_d = sum_rel_q;
    set_end_d = set_end_q; diff_d = diff_q; mag_zero_d = mag_zero_q; ae_d = ae_q;
    bin_d = bin_q; bin_ok_d = bin_ok_q;
    idx_d = idx_q; met_d = met_q; val_d = val_q;
    tot_d = tot_q; cum_d = cum_q; need_d = need_q; k_d = k_q;
    sq_rad_d = sq_rad_q; sq_rem_d = sq_rem_q; sq_root_d = sq_root_q; sq_cnt_d = sq_cnt_q;
    out_valid_d = out_valid_q; out_d = out_q;
    div_req = '0;
    ram_we = 1'b0; ram_addr = bin_q; ram_wdata = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        ram_we = 1'b1; ram_addr = idx_q[AW-1:0];
        if (idx_q == CW'(MaxBins - 1)) begin
          state_d = S_IDLE;
          max_abs_d = '0; max_rel_d = '0; cnt_d = '0;
          sum_abs_d = '0; sum_sq_d = '0; sum_rel_d = '0;
        end else idx_d = idx_q + CW'(1);
      end
      S_IDLE: if (in_valid_i) begin
        diff_d = 33'({in_data_i.original_value[31], in_data_i.original_value} -
                     {in_data_i.quantized_value[31], in_data_i.quantized_value});
        if (diff_d[32]) diff_d = 33'(-diff_d);
        mag_zero_d = (mag == '0);
        set_end_d = in_data_i.set_end;
        div_req.start = 1'b1;
        div_req.dividend = {31'd0, diff_d, 16'd0};
        div_req.divisor = {31'd0, mag};
        state_d = S_RDIV;
      end
      S_RDIV: if (!div_busy) begin
        ae_d = diff_q[32] ? '1 : diff_q[31:0];
        state_d = S_ACC;
        // zero original: relative error is defined as zero
        if (mag_zero_q) val_d = '0;
        else val_d = (div_quot[79:32] != '0) ? 64'hFFFF_FFFF : {32'd0, div_quot[31:0]};
      end
      S_ACC: begin
        if (ae_q > max_abs_q) max_abs_d = ae_q;
        sum_abs_d = sat_add(sum_abs_q, {32'd0, ae_q});
        sum_sq_d  = sat_add(sum_sq_q, {16'd0, ae_sq[63:16]});
        if (val_q[31:0] > max_rel_q) max_rel_d = val_q[31:0];
        sum_rel_d = sat_add(sum_rel_q, {32'd0, val_q[31:0]});
        if (cnt_q != '1) cnt_d = cnt_q + 32'd1;
        bin_ok_d = (n_bins != '0) && (ae_bin[40:16] < 25'(n_bins));
        bin_d = ae_bin[16 +: AW];
        met_d = MET_MAX_ABS;
        state_d = S_HRD;
      end
      S_HRD: state_d = bin_ok_q ? S_HWR : (set_end_q ? S_MDIV : S_IDLE);
      S_HWR: begin
        ram_we = (ram_rdata != '1);
        ram_wdata = ram_rdata + 32'd1;
        state_d = set_end_q ? S_MDIV : S_IDLE;
      end
      S_MDIV: begin
        div_req.start = 1'b1;
        div_req.divisor = {32'd0, cnt_q};
        div_req.dividend = (met_q == MET_MEAN_ABS) ? {16'd0, sum_abs_q} :
                           (met_q == MET_MSE) ? {16'd0, sum_sq_q} : {16'd0, sum_rel_q};
        state_d = S_MWAIT;
        if (met_q == MET_MAX_ABS) begin
          div_req.start = 1'b0;
          val_d = {32'd0, max_abs_q};
          state_d = S_EMIT;
        end
      end
      S_MWAIT: if (!div_busy && !div_req.start) begin
        val_d = div_quot[63:0];
        if (met_q == MET_MSE) begin
          sq_rad_d = {div_quot[63:0], 16'd0};
          sq_rem_d = '0; sq_root_d = '0; sq_cnt_d = 6'd39;
        end
        state_d = S_EMIT;
      end
      S_SQRT: begin
        sq_rad_d = {sq_rad_q[77:0], 2'b00};
        if (sq_rem_sh >= sq_trial) begin
          sq_rem_d = sq_rem_sh - sq_trial;
          sq_root_d = {sq_root_q[38:0], 1'b1};
        end else begin
          sq_rem_d = sq_rem_sh;
          sq_root_d = {sq_root_q[38:0], 1'b0};
        end
        if (sq_cnt_q == '0) begin
          val_d = {24'd0, sq_root_d};
          state_d = S_EMIT;
        end else sq_cnt_d = sq_cnt_q - 6'd1;
      end
      S_TOT: begin
        ram_addr = idx_q[AW-1:0];
        state_d = S_TOTW;
      end
      S_TOTW: begin
        ram_addr = idx_q[AW-1:0];
        tot_d = tot_q + {32'd0, ram_rdata};
        if (idx_q + CW'(1) >= n_bins) begin
          k_d = 4'd1; state_d = S_PMUL;
        end else begin
          idx_d = idx_q + CW'(1); state_d = S_TOT;
        end
      end
      S_PMUL: begin
        need_d = {4'd0, tot_q} * 68'(k_q);
        cum_d = '0; idx_d = '0;
        state_d = (tot_q == '0) ? S_PDIV : S_PSCAN;
        if (tot_q == '0) idx_d = n_bins;
      end
      S_PSCAN: begin
        ram_addr = idx_q[AW-1:0];
        state_d = S_PCHK;
      end
      S_PCHK: begin
        ram_addr = idx_q[AW-1:0];
        cum_d = cum_next;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        if (cum10 >= need_q || tot_q == '0 || idx_q >= n_bins) begin
          div_req.start = 1'b1;
          div_req.dividend = {{(64-CW){1'b0}}, idx_q, 16'd0};
          div_req.divisor = {{(64-CW){1'b0}}, n_bins};
          state_d = S_MWAIT;
        end else begin
          idx_d = idx_q + CW'(1);
          state_d = S_PSCAN;
        end
      end
      S_EMIT: if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_d.metric_index = met_q;
        out_d.metric_value = val_q;
        out_d.last_metric = (met_q == MET_PASS);
        state_d = S_WOUT;
      end
      S_WOUT: begin
        met_d = met_q + 5'd1;
        unique case (met_q)
          MET_MAX_ABS, MET_MEAN_ABS: state_d = S_MDIV;
          MET_MSE: state_d = S_SQRT;
          MET_RMSE: begin val_d = {32'd0, max_rel_q}; state_d = S_EMIT; end
          MET_MAX_REL: state_d = S_MDIV;
          MET_MEAN_REL: begin val_d = {32'd0, cnt_q}; state_d = S_EMIT; end
          MET_COUNT: begin
            tot_d = '0; idx_d = '0;
            if (n_bins == '0) begin val_d = '0; state_d = S_EMIT; end
            else state_d = S_TOT;
          end
          MET_PASS: begin idx_d = '0; state_d = S_FIN; end
          default: begin
            if (met_q == MET_PASS - 5'd1) begin
              val_d = {63'd0, (max_abs_q <= abs_lim_q) && (max_rel_q <= rel_lim_q)};
              state_d = S_EMIT;
            end else if (n_bins == '0) begin
              val_d = '0; state_d = S_EMIT;
            end else begin
              k_d = k_q + 4'd1; state_d = S_PMUL;
            end
          end
        endcase
      end
      S_FIN: state_d = S_CLR;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; idx_q <= '0; out_valid_q <= 1'b0;
      max_abs_q <= '0; max_rel_q <= '0; cnt_q <= '0;
      sum_abs_q <= '0; sum_sq_q <= '0; sum_rel_q <= '0;
      met_q <= '0; k_q <= '0; set_end_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; out_valid_q <= out_valid_d;
      max_abs_q <= max_abs_d; max_rel_q <= max_rel_d; cnt_q <= cnt_d;
      sum_abs_q <= sum_abs_d; sum_sq_q <= sum_sq_d; sum_rel_q <= sum_rel_d;
      met_q <= met_d; k_q <= k_d; set_end_q <= set_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d; mag_zero_q <= mag_zero_d; ae_q <= ae_d;
    bin_q <= bin_d; bin_ok_q <= bin_ok_d;
    val_q <= val_d; tot_q <= tot_d; cum_q <= cum_d;
    need_q <= need_d; sq_rad_q <= sq_rad_d; sq_rem_q <= sq_rem_d;
    sq_root_q <= sq_root_d; sq_cnt_q <= sq_cnt_d; out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_in_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RDIV))
    else $error("input accepted outside idle");
  a_last_is_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_metric) |-> (out_data_o.metric_index == MET_PASS))
    else $error("last flag on wrong metric");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pending result dropped or changed");
`endif
endmodule
